/* rtl/single_edit_dictionary_match_defines.svh */
// Assertion macros for the dictionary match block
`ifndef SINGLE_EDIT_DICTIONARY_MATCH_DEFINES_SVH
`define SINGLE_EDIT_DICTIONARY_MATCH_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle
`define SEDM_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle
`define SEDM_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

/* rtl/sedm_pkg.sv */
// ----------------------------------------------------------------------------
// sedm_pkg
// Shared types and codes of the single-edit dictionary match block.
// ----------------------------------------------------------------------------
`default_nettype none
package sedm_pkg;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_CORRECT = 2'd0;
   localparam logic [1:0] ST_MISSPELL = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;

   // kind of command handed from front to back
   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_CLEAR,
      CMD_QCHAR,
      CMD_QEND
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   character;
      logic         word_end;
   } cmd_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FETCH,
      BK_CMP,
      BK_DONE,
      BK_OUT
   } back_state_type;

endpackage
`default_nettype wire

/* rtl/single_edit_dictionary_match.sv */
// A query end scans the stored entries one at a time, each fetched and then
// compared, through the dictionary memory's single read port.
// Loads, query characters and clears are each handled in the back end's idle state.
// A four-entry command queue lets the front accept while the back scans.
// Reset is synchronous and active high; it empties the dictionary and queue.
// No clearing pass: the dictionary memory is read only where it was written.
`default_nettype none
module single_edit_dictionary_match
   import sedm_pkg::*;
#(
   parameter int MAX_WORDS = 1024,
   parameter int MAX_LEN   = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_character,
   input  wire logic       req_word_end,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_status,
   output logic [9:0]      rsp_entry_index
);

   logic    cmd_valid, cmd_pop;
   cmd_type cmd_data;

   sedm_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_operation, .req_character,
      .req_word_end, .cmd_valid, .cmd_pop, .cmd_data
   );

   sedm_back #(.MAX_WORDS(MAX_WORDS), .MAX_LEN(MAX_LEN)) u_back (
      .clock, .reset, .cmd_valid, .cmd_pop, .cmd_data, .rsp_valid, .rsp_stall,
      .rsp_status, .rsp_entry_index
   );

endmodule
`default_nettype wire

/* rtl/sedm_front.sv */
// ----------------------------------------------------------------------------
// sedm_front
// Accept items, classify them and push commands into a short queue.
// ----------------------------------------------------------------------------
`default_nettype none
module sedm_front
   import sedm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_character,
   input  wire logic       req_word_end,
   output logic            cmd_valid,
   input  wire logic       cmd_pop,
   output cmd_type         cmd_data
);

   localparam int DEPTH = 4;

   cmd_type    fifo_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       push;
   cmd_type    cmd_new;

   assign req_stall = (count_ff == 3'(DEPTH));
   assign cmd_valid = (count_ff != 3'd0);
   assign cmd_data  = fifo_ff[rd_ptr_ff];

   // classify the item; unused operation codes push nothing
   always_comb begin
      cmd_new.character = req_character;
      cmd_new.word_end  = req_word_end;
      cmd_new.kind      = CMD_LOAD;
      push              = req_valid && !req_stall;
      unique case (req_operation)
         OP_LOAD:  cmd_new.kind = CMD_LOAD;
         OP_CLEAR: cmd_new.kind = CMD_CLEAR;
         OP_QUERY: cmd_new.kind = req_word_end ? CMD_QEND : CMD_QCHAR;
         default:  push = 1'b0;
      endcase
   end

   // advance queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + 2'(push);
      rd_ptr_in = rd_ptr_ff + 2'(cmd_pop);
      count_in  = count_ff + 3'(push) - 3'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule
`default_nettype wire

/* rtl/sedm_back.sv */
// ----------------------------------------------------------------------------
// sedm_back
// Execute loads, clears and query scans against the dictionary memory.
// ----------------------------------------------------------------------------
`default_nettype none
`include "single_edit_dictionary_match_defines.svh"
module sedm_back
   import sedm_pkg::*;
#(
   parameter int MAX_WORDS = 1024,
   parameter int MAX_LEN   = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       cmd_valid,
   output logic            cmd_pop,
   input  wire cmd_type    cmd_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_status,
   output logic [9:0]      rsp_entry_index
);

   localparam int WB = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int CB = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_WORDS + 1);
   localparam int LW = $clog2(MAX_LEN + 1);

   // one memory row holds a whole word
   logic [MAX_LEN*8-1:0] dict_mem [MAX_WORDS];
   logic [LW-1:0]        len_mem  [MAX_WORDS];
   logic [MAX_LEN*8-1:0] load_buf_ff, query_ff;
   logic [LW-1:0]        load_len_ff, query_len_ff;
   logic [CW-1:0]        word_count_ff;
   logic [WB-1:0]        scan_ff, scan_in;
   logic [MAX_LEN*8-1:0] row_ff;
   logic [LW-1:0]        row_len_ff;
   logic [1:0]           status_ff;
   logic [WB-1:0]        index_ff;
   logic                 near_ff;
   back_state_type       state_ff, state_in;

   logic [MAX_LEN*8-1:0] load_next;
   logic [LW-1:0]        load_len_next;
   logic                 do_load, do_write, last_entry;
   logic [1:0]           cls;

   // pick state transitions
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (cmd_valid && cmd_data.kind == CMD_QEND) begin
            state_in = (word_count_ff == '0) ? BK_DONE : BK_FETCH;
         end
         BK_FETCH: state_in = BK_CMP;
         BK_CMP:   state_in = (cls == ST_CORRECT || last_entry) ? BK_DONE : BK_FETCH;
         BK_DONE:  state_in = BK_OUT;
         BK_OUT:   if (!rsp_stall) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // drive sequencer outputs
   always_comb begin
      cmd_pop    = 1'b0;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         BK_IDLE: cmd_pop = cmd_valid && cmd_data.kind != CMD_QEND;
         BK_OUT:  begin
            rsp_valid = 1'b1;
            cmd_pop   = !rsp_stall;
         end
         default: ;
      endcase
   end

   assign rsp_status      = status_ff;
   assign rsp_entry_index = (status_ff == ST_UNKNOWN) ? 10'd0 : 10'(index_ff);
   assign last_entry      = (CW'(scan_ff) + CW'(1) >= word_count_ff);

   // build the next load buffer
   always_comb begin
      load_next     = load_buf_ff;
      load_len_next = load_len_ff;
      if (load_len_ff < LW'(MAX_LEN)) begin
         load_next[load_len_ff[CB-1:0]*8 +: 8] = cmd_data.character;
         load_len_next = load_len_ff + LW'(1);
      end
   end
   assign do_load  = state_ff == BK_IDLE && cmd_pop && cmd_data.kind == CMD_LOAD &&
                     word_count_ff < CW'(MAX_WORDS);
   assign do_write = do_load && cmd_data.word_end;

   // classify one row against the query: length-relation plus edit checks
   always_comb begin
      logic eq_all, sub_ok, swp_ok, ins_ok;
      logic [MAX_LEN-1:0] d, fwd, bwd;
      logic [MAX_LEN*8-1:0] sa, la;
      logic [LW-1:0] ls, ll;
      logic [MAX_LEN:0] pre, suf;
      cls = ST_UNKNOWN;
      for (int k = 0; k < MAX_LEN; k++) begin
         d[k] = (k < row_len_ff) && (row_ff[k*8 +: 8] != query_ff[k*8 +: 8]);
      end
      eq_all = (d == '0);
      sub_ok = $countones(d) == 1;
      swp_ok = 1'b0;
      for (int k = 0; k + 1 < MAX_LEN; k++) begin
         if ((d & ~(MAX_LEN'(3) << k)) == '0 && d[k] && d[k+1] &&
             row_ff[k*8 +: 8] == query_ff[(k+1)*8 +: 8] &&
             row_ff[(k+1)*8 +: 8] == query_ff[k*8 +: 8]) swp_ok = 1'b1;
      end
      if (row_len_ff < query_len_ff) begin
         sa = row_ff; la = query_ff; ls = row_len_ff; ll = query_len_ff;
      end else begin
         sa = query_ff; la = row_ff; ls = query_len_ff; ll = row_len_ff;
      end
      // prefix match s[k]==l[k], shifted match s[k]==l[k+1]
      for (int k = 0; k < MAX_LEN; k++) begin
         fwd[k] = (k >= ls) || sa[k*8 +: 8] == la[k*8 +: 8];
         bwd[k] = (k >= ls) || (k + 1 < MAX_LEN && sa[k*8 +: 8] == la[(k+1)*8 +: 8]);
      end
      pre[0] = 1'b1;
      for (int k = 0; k < MAX_LEN; k++) pre[k+1] = pre[k] & fwd[k];
      suf[MAX_LEN] = 1'b1;
      for (int k = MAX_LEN - 1; k >= 0; k--) suf[k] = suf[k+1] & bwd[k];
      ins_ok = 1'b0;
      for (int k = 0; k <= MAX_LEN; k++) if (pre[k] && suf[k]) ins_ok = 1'b1;
      if (row_len_ff == query_len_ff) begin
         if (eq_all) cls = ST_CORRECT;
         else if (sub_ok || swp_ok) cls = ST_MISSPELL;
      end else if (ll == ls + LW'(1)) begin
         if (ins_ok) cls = ST_MISSPELL;
      end
   end

   assign scan_in = (state_ff == BK_CMP) ? scan_ff + WB'(1) : '0;

   // sequencer and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         word_count_ff <= '0;
         load_len_ff   <= '0;
         query_len_ff  <= '0;
         scan_ff       <= '0;
         near_ff       <= 1'b0;
         status_ff     <= ST_UNKNOWN;
      end else begin
         state_ff <= state_in;
         scan_ff  <= (state_ff == BK_IDLE) ? '0 : (state_ff == BK_CMP ? scan_in : scan_ff);
         if (state_ff == BK_IDLE && cmd_pop) begin
            unique case (cmd_data.kind)
               CMD_LOAD: begin
                  if (!do_load) load_len_ff <= '0;
                  else if (cmd_data.word_end) begin
                     load_len_ff   <= '0;
                     word_count_ff <= word_count_ff + CW'(1);
                  end else load_len_ff <= load_len_next;
               end
               CMD_CLEAR: begin
                  word_count_ff <= '0;
                  load_len_ff   <= '0;
               end
               CMD_QCHAR: if (query_len_ff < LW'(MAX_LEN)) query_len_ff <= query_len_ff + LW'(1);
               default: ;
            endcase
         end
         if (state_ff == BK_IDLE && state_in != BK_IDLE) begin
            near_ff   <= 1'b0;
            status_ff <= ST_UNKNOWN;
            if (query_len_ff < LW'(MAX_LEN)) query_len_ff <= query_len_ff + LW'(1);
         end
         if (state_ff == BK_CMP) begin
            if (cls == ST_CORRECT) begin
               status_ff <= ST_CORRECT;
               index_ff  <= scan_ff;
            end else if (cls == ST_MISSPELL && !near_ff) begin
               near_ff   <= 1'b1;
               status_ff <= ST_MISSPELL;
               index_ff  <= scan_ff;
            end
         end
         if (state_ff == BK_OUT && !rsp_stall) query_len_ff <= '0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (do_load) load_buf_ff <= load_next;
      if (state_ff == BK_IDLE && cmd_valid &&
          (cmd_data.kind == CMD_QCHAR || cmd_data.kind == CMD_QEND) &&
          query_len_ff < LW'(MAX_LEN)) begin
         query_ff[query_len_ff[CB-1:0]*8 +: 8] <= cmd_data.character;
      end
   end

   // dictionary memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         dict_mem[word_count_ff[WB-1:0]] <= load_next;
         len_mem[word_count_ff[WB-1:0]]  <= load_len_next;
      end
      row_ff     <= dict_mem[scan_ff];
      row_len_ff <= len_mem[scan_ff];
   end

   `SEDM_ASSERT_IMP(a_out_hold, clock, reset, rsp_valid && rsp_stall, state_in == BK_OUT, "result dropped while stalled")
   `SEDM_ASSERT_IMP(a_unknown_idx, clock, reset, rsp_valid && rsp_status == ST_UNKNOWN, rsp_entry_index == 10'd0, "unknown with index")
   `SEDM_ASSERT_NEXT(a_cmp_fetch, clock, reset, state_ff == BK_FETCH, state_ff == BK_CMP, "fetch not followed by compare")

endmodule
`default_nettype wire
